FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file spq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/spq_pkg.sv
// Types and constants of the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } in_t;

    typedef struct packed {
        logic               head_valid;
        logic signed [31:0] head_value;
        logic signed [31:0] head_priority;
        logic [4:0]         entry_count;
        logic               dropped;
    } out_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/spq_cell.sv
// One slot of the sorted shift-register queue.
`default_nettype none
module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::cell_ctl_t ctl,
    input  wire logic               occupied,
    input  wire spq_pkg::entry_t    new_entry,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire logic               left_ins,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    ins
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    assign ins   = !occupied || (entry_reg.prio < new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.enq && ins)
        begin
            entry_next = left_ins ? left_entry : new_entry;
        end
        else if (ctl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of slots kept in priority order.
// The result of an operation is shown in the cycle after start is taken.
// Throughput: one operation per cycle; busy stays low, every slot updates at once.
// Reset clears the entry count, the result strobe and the dropped flag; slot contents need no reset.
// The receiver cannot stall: done is high for exactly one cycle per operation.
`default_nettype none
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire spq_pkg::in_t cmd,
    output logic              done,
    output spq_pkg::out_t     result
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic          done_next;
    logic          drop_reg;
    logic          drop_next;

    logic          take;
    logic          full;
    logic          empty;
    cell_ctl_t     ctl;
    entry_t        new_entry;
    entry_t        cells  [CAPACITY];
    logic          ins    [CAPACITY];

    assign busy  = 1'b0;
    assign take  = start && !busy;
    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);

    assign ctl.enq = take && (cmd.opcode == OP_ENQUEUE) && !full;
    assign ctl.deq = take && (cmd.opcode == OP_DEQUEUE) && !empty;

    assign new_entry.value = cmd.item_value;
    assign new_entry.prio  = cmd.item_priority;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            spq_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (count_reg > CW'(i)),
                .new_entry   (new_entry),
                .left_entry  ((i == 0) ? entry_t'('0) : cells[(i == 0) ? 0 : i - 1]),
                .left_ins    ((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i - 1]),
                .right_entry ((i == CAPACITY - 1) ? entry_t'('0)
                                : cells[(i == CAPACITY - 1) ? i : i + 1]),
                .entry       (cells[i]),
                .ins         (ins[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.deq)
        begin
            count_next = count_reg - CW'(1);
        end
        done_next = take;
        drop_next = take && (cmd.opcode == OP_ENQUEUE) && full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            drop_reg  <= drop_next;
        end
    end

    assign done                 = done_reg;
    assign result.head_valid    = !empty;
    assign result.head_value    = empty ? 32'sd0 : cells[0].value;
    assign result.head_priority = empty ? 32'sd0 : cells[0].prio;
    assign result.entry_count   = 5'(count_reg);
    assign result.dropped       = drop_reg;

endmodule
`default_nettype wire

FILE: hdl/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module spq_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire spq_pkg::in_t  cmd,
    input wire logic          done,
    input wire spq_pkg::out_t result
);
    import spq_pkg::*;

    `ASSERT_NEXT(a_beat_done, start && !busy, done)
    `ASSERT_NEXT(a_no_spurious, !(start && !busy), !done)
    `ASSERT_SAME(a_head_count, done, result.head_valid == (result.entry_count != 5'd0))
    `ASSERT_SAME(a_empty_zero, !result.head_valid, {result.head_value, result.head_priority} == '0)
    `ASSERT_NEXT(a_drop_enq, start && !busy && cmd.opcode == OP_DEQUEUE, !result.dropped)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
`default_nettype wire
